// ===== hw/rtl/mtsc_pkg.sv =====
// ----------------------------------------------------------------------------
// mtsc_pkg
// shared types, constants and helpers of the machine terminal signal unit
// ----------------------------------------------------------------------------
package mtsc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_COUNT    = 30;
  localparam int ROT_STAGES    = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;
  localparam int ROT_W         = 5;
  localparam int RED_STEPS     = 15;
  localparam int RED_W         = 4;

  localparam int TWO_PI_Q    = 411775;
  localparam int PI_Q        = 205887;
  localparam int HALF_PI_Q   = 102944;
  localparam int CORDIC_GAIN = 652032874;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_RS   = 2'd0,
    REG_XD   = 2'd1,
    REG_XDP  = 2'd2,
    REG_KIND = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_CLASSICAL = 2'd0,
    KIND_THIRD     = 2'd1,
    KIND_FOURTH    = 2'd2,
    KIND_FIFTH     = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic signed [31:0] id;
    logic signed [31:0] iq;
    logic signed [31:0] efd;
    logic signed [31:0] flux;
  } side_t;

  typedef struct packed {
    logic [33:0] acc;
    side_t       side;
  } red_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic               neg;
    side_t              side;
  } rot_t;

  typedef struct packed {
    logic [30:0]        rs;
    logic signed [31:0] xdiff;
    kind_t              kind;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] vd;
    logic signed [31:0] vq;
    logic signed [31:0] power;
    logic signed [31:0] torque;
    logic signed [31:0] fc;
  } res_t;

  // 2*pi scaled by 2^k, the subtrahend of one reduction step
  function automatic logic [33:0] red_step(input logic [RED_W-1:0] k);
    return 34'(TWO_PI_Q) << k;
  endfunction

  function automatic logic [29:0] atan_q30(input logic [ROT_W-1:0] i);
    logic [29:0] a;
    unique case (i)
      5'd0:  a = 30'd843314856;
      5'd1:  a = 30'd497837829;
      5'd2:  a = 30'd263043836;
      5'd3:  a = 30'd133525158;
      5'd4:  a = 30'd67021686;
      5'd5:  a = 30'd33543515;
      5'd6:  a = 30'd16775850;
      5'd7:  a = 30'd8388437;
      5'd8:  a = 30'd4194282;
      5'd9:  a = 30'd2097149;
      5'd10: a = 30'd1048575;
      5'd11: a = 30'd524287;
      5'd12: a = 30'd262143;
      5'd13: a = 30'd131071;
      5'd14: a = 30'd65535;
      5'd15: a = 30'd32767;
      5'd16: a = 30'd16383;
      5'd17: a = 30'd8191;
      5'd18: a = 30'd4095;
      5'd19: a = 30'd2047;
      5'd20: a = 30'd1023;
      5'd21: a = 30'd511;
      5'd22: a = 30'd255;
      5'd23: a = 30'd127;
      5'd24: a = 30'd63;
      5'd25: a = 30'd31;
      5'd26: a = 30'd15;
      5'd27: a = 30'd8;
      5'd28: a = 30'd4;
      5'd29: a = 30'd2;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/mtsc_reduce_cell.sv =====
// ----------------------------------------------------------------------------
// mtsc_reduce_cell
// one conditional subtract of 2*pi*2^k in the angle reduction chain
// ----------------------------------------------------------------------------
module mtsc_reduce_cell import mtsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [RED_W-1:0] stage,
  input  logic             in_valid,
  output logic             in_ready,
  input  red_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output red_t             out_data
);

  logic [33:0] step;
  red_t        data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    step      = red_step(stage);
    data_next = in_data;
    if (in_data.acc >= step) data_next.acc = in_data.acc - step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) out_data <= data_next;
  end

  // after the step the remainder is below this cell's subtrahend
  a_red_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.acc < red_step(stage)))
    else $error("reduction remainder out of range");

endmodule

// ===== hw/rtl/mtsc_rot_cell.sv =====
// ----------------------------------------------------------------------------
// mtsc_rot_cell
// one cordic micro-rotation in rotation mode
// ----------------------------------------------------------------------------
module mtsc_rot_cell import mtsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [ROT_W-1:0] stage,
  input  logic             in_valid,
  output logic             in_ready,
  input  rot_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rot_t             out_data
);

  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [32:0] at;
  rot_t               data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    xs        = in_data.x >>> stage;
    ys        = in_data.y >>> stage;
    at        = $signed({3'b000, atan_q30(stage)});
    data_next = in_data;
    if (!in_data.z[32]) begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - at;
    end else begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) out_data <= data_next;
  end

  // the vector never grows to magnitude 2.0 in q2.30 on either axis
  a_rot_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.x < 34'sd2147483647 && out_data.x > -34'sd2147483647 &&
                   out_data.y < 34'sd2147483647 && out_data.y > -34'sd2147483647))
    else $error("cordic vector overflow");

endmodule

// ===== hw/rtl/mtsc_arith.sv =====
// ----------------------------------------------------------------------------
// mtsc_arith
// five stage product pipeline: voltages, power, torque, field current
// ----------------------------------------------------------------------------
module mtsc_arith import mtsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  rot_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic [4:0] vld;
  logic [4:0] rdy;
  logic [4:0] prv;

  assign rdy[4] = !vld[4] || out_ready;
  assign rdy[3] = !vld[3] || rdy[4];
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];
  assign prv    = {vld[3:0], in_valid};
  assign in_ready  = rdy[0];
  assign out_valid = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < 5; i++) begin
        if (rdy[i]) vld[i] <= prv[i];
      end
    end
  end

  // stage 1: sine/cosine sign fix and first products
  logic signed [33:0] s_full, c_full;
  logic signed [31:0] s32, c32;
  logic signed [63:0] pv, pc, idsq, iqsq, pdiff;
  side_t              side1;

  always_comb begin
    s_full = in_data.neg ? -in_data.y : in_data.y;
    c_full = in_data.neg ? -in_data.x : in_data.x;
    s32    = s_full[31:0];
    c32    = c_full[31:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && prv[0]) begin
      pv    <= in_data.side.v * s32;
      pc    <= in_data.side.v * c32;
      idsq  <= in_data.side.id * in_data.side.id;
      iqsq  <= in_data.side.iq * in_data.side.iq;
      pdiff <= cfg.xdiff * in_data.side.id;
      side1 <= in_data.side;
    end
  end

  // stage 2: rounding of voltages, current magnitude, reactive drop
  logic signed [64:0] tvd, tvq, tdrop;
  logic signed [31:0] vd2, vq2;
  logic [63:0]        msq;
  logic signed [48:0] drop2;
  side_t              side2;

  always_comb begin
    tvd = -$signed({pv[63], pv}) + 65'sd536870912;
    tvq = $signed({pc[63], pc}) + 65'sd536870912;
    tdrop = $signed({pdiff[63], pdiff}) + 65'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && prv[1]) begin
      vd2   <= sat32(66'(tvd >>> 30));
      vq2   <= sat32(66'(tvq >>> 30));
      msq   <= $unsigned(idsq) + $unsigned(iqsq);
      drop2 <= 49'(tdrop >>> 16);
      side2 <= side1;
    end
  end

  // stage 3: power products, loss partial products, field current
  logic signed [63:0] pd, pq;
  logic [62:0]        lh, ll;
  logic signed [31:0] vd3, vq3, fc3, fc_sel;
  logic signed [49:0] ftmp;

  always_comb begin
    ftmp = 50'(side2.flux) - 50'(drop2);
    unique case (cfg.kind)
      KIND_CLASSICAL: fc_sel = side2.efd;
      KIND_FIFTH:     fc_sel = side2.flux;
      KIND_THIRD,
      KIND_FOURTH:    fc_sel = sat32(66'(ftmp));
      default:        fc_sel = side2.efd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[2] && prv[2]) begin
      pd  <= vd2 * side2.id;
      pq  <= vq2 * side2.iq;
      lh  <= 63'(cfg.rs) * 63'(msq[63:32]);
      ll  <= 63'(cfg.rs) * 63'(msq[31:0]);
      vd3 <= vd2;
      vq3 <= vq2;
      fc3 <= fc_sel;
    end
  end

  // stage 4: rounded power and loss
  logic signed [64:0] psum;
  logic signed [48:0] p4;
  logic [63:0]        loss4, lround;
  logic signed [31:0] vd4, vq4, fc4;

  always_comb begin
    psum   = $signed({pd[63], pd}) + $signed({pq[63], pq}) + 65'sd32768;
    lround = (64'(ll) + 64'h8000_0000) >> 32;
  end

  always_ff @(posedge clk) begin
    if (rdy[3] && prv[3]) begin
      p4    <= 49'(psum >>> 16);
      loss4 <= 64'(lh) + lround;
      vd4   <= vd3;
      vq4   <= vq3;
      fc4   <= fc3;
    end
  end

  // stage 5: saturation into the output register
  always_ff @(posedge clk) begin
    if (rdy[4] && prv[4]) begin
      out_data.vd     <= vd4;
      out_data.vq     <= vq4;
      out_data.power  <= sat32(66'(p4));
      out_data.torque <= sat32(66'(p4) + $signed({2'b00, loss4}));
      out_data.fc     <= fc4;
    end
  end

  // with no resistive loss torque equals power on the loss path
  a_loss_zero: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && loss4 == 64'd0 && rdy[4]) |=> (out_data.torque == out_data.power))
    else $error("torque differs from power with zero loss");

endmodule

// ===== hw/rtl/machine_terminal_signal_compute.sv =====
// ----------------------------------------------------------------------------
// machine_terminal_signal_compute
// d/q terminal voltages, power, torque and field current of a synchronous
// machine, signed q16.16 per unit
// ----------------------------------------------------------------------------
// The unit takes one sample per clock while not stalled and returns one result
// per sample, in order. A sample passes a chain of 15 angle reduction cells
// (one compare and subtract of 2*pi*2^k each), CORDIC_STAGES rotation cells
// and a five stage product pipeline, and the throughput is one transfer per
// cycle while the output accepts. Every stage has its own valid bit and holds
// only while the stage after it is full and stalled, so bubbles are squeezed
// out and the input keeps taking samples while a result waits on the output
// register, until every stage is full. Configuration writes take effect at
// once and are meant to happen while the pipeline is empty.
// ----------------------------------------------------------------------------
module machine_terminal_signal_compute import mtsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  // sample channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] bus_voltage,
  input  logic signed [31:0] bus_angle,
  input  logic signed [31:0] rotor_angle,
  input  logic signed [31:0] direct_current,
  input  logic signed [31:0] quadrature_current,
  input  logic signed [31:0] excitation_voltage,
  input  logic signed [31:0] field_flux_state,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] direct_voltage,
  output logic signed [31:0] quadrature_voltage,
  output logic signed [31:0] active_power,
  output logic signed [31:0] air_gap_torque,
  output logic signed [31:0] field_current
);

  // configuration registers
  logic [30:0] rs;
  logic [30:0] xd;
  logic [30:0] xdp;
  kind_t       kind;
  cfg_t        cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      rs   <= '0;
      xd   <= 31'd65536;
      xdp  <= 31'd19661;
      kind <= KIND_CLASSICAL;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RS:   rs   <= cfg_data;
        REG_XD:   xd   <= cfg_data;
        REG_XDP:  xdp  <= cfg_data;
        REG_KIND: kind <= kind_t'(cfg_data[1:0]);
        default:  rs   <= rs;
      endcase
    end
  end

  // reactance difference may go negative
  assign cfg.rs    = rs;
  assign cfg.xdiff = $signed({1'b0, xd}) - $signed({1'b0, xdp});
  assign cfg.kind  = kind;

  // angle difference offset by 2*pi*2^14 so the reduction chain sees a
  // non-negative value that is congruent modulo 2*pi
  logic signed [32:0] adiff;
  red_t               red_in;

  assign adiff         = $signed({rotor_angle[31], rotor_angle}) -
                         $signed({bus_angle[31], bus_angle});
  assign red_in.acc    = 34'($unsigned({adiff[32], adiff})) + red_step(4'(RED_STEPS - 1));
  assign red_in.side.v    = bus_voltage;
  assign red_in.side.id   = direct_current;
  assign red_in.side.iq   = quadrature_current;
  assign red_in.side.efd  = excitation_voltage;
  assign red_in.side.flux = field_flux_state;

  // reduction chain, largest multiple first
  red_t [RED_STEPS:0] red_d;
  logic [RED_STEPS:0] red_v;
  logic [RED_STEPS:0] red_r;

  assign red_d[0] = red_in;
  assign red_v[0] = in_valid;
  assign in_ready = red_r[0];

  for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
    mtsc_reduce_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage     (RED_W'(RED_STEPS - 1 - j)),
      .in_valid  (red_v[j]),
      .in_ready  (red_r[j]),
      .in_data   (red_d[j]),
      .out_valid (red_v[j+1]),
      .out_ready (red_r[j+1]),
      .out_data  (red_d[j+1])
    );
  end

  // fold the remainder into [-pi/2, pi/2], flipping both outputs when needed
  logic signed [20:0] rem;
  logic               fold_neg;
  rot_t               rot_in;

  always_comb begin
    rem      = $signed({2'b00, red_d[RED_STEPS].acc[18:0]});
    fold_neg = 1'b0;
    if (rem > 21'sd205887) rem = rem - 21'sd411775;
    if (rem > 21'sd102944) begin
      rem      = rem - 21'sd205887;
      fold_neg = 1'b1;
    end else if (rem < -21'sd102944) begin
      rem      = rem + 21'sd205887;
      fold_neg = 1'b1;
    end
    rot_in.x    = 34'(CORDIC_GAIN);
    rot_in.y    = '0;
    rot_in.z    = 33'(rem) <<< 14;
    rot_in.neg  = fold_neg;
    rot_in.side = red_d[RED_STEPS].side;
  end

  // rotation chain
  rot_t [ROT_STAGES:0] rot_d;
  logic [ROT_STAGES:0] rot_v;
  logic [ROT_STAGES:0] rot_r;

  assign rot_d[0]         = rot_in;
  assign rot_v[0]         = red_v[RED_STEPS];
  assign red_r[RED_STEPS] = rot_r[0];

  for (genvar j = 0; j < ROT_STAGES; j++) begin : g_rot
    mtsc_rot_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage     (ROT_W'(j)),
      .in_valid  (rot_v[j]),
      .in_ready  (rot_r[j]),
      .in_data   (rot_d[j]),
      .out_valid (rot_v[j+1]),
      .out_ready (rot_r[j+1]),
      .out_data  (rot_d[j+1])
    );
  end

  // products and the output register
  res_t res;

  mtsc_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (rot_v[ROT_STAGES]),
    .in_ready  (rot_r[ROT_STAGES]),
    .in_data   (rot_d[ROT_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res)
  );

  assign direct_voltage     = res.vd;
  assign quadrature_voltage = res.vq;
  assign active_power       = res.power;
  assign air_gap_torque     = res.torque;
  assign field_current      = res.fc;

  // a stall at the input can only come from a result held at the output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // with no result at the output, next cycle the input is free or a result has arrived
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |=> in_ready || out_valid)
    else $error("stall without pending result");

  // right after reset nothing appears at the output
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

// ===== tb/tb_machine_terminal_signal_compute.sv =====
// ----------------------------------------------------------------------------
// tb_machine_terminal_signal_compute
// self-checking bench for the machine terminal signal unit: an in-bench
// predictor computes each expected result, a monitor compares every output
// transfer in order, and stimulus sweeps angles, currents and settings
// ----------------------------------------------------------------------------
module tb_machine_terminal_signal_compute;
  import mtsc_pkg::*;

  // one input sample, fields as on the ports
  typedef struct {
    logic signed [31:0] v;
    logic signed [31:0] ba;
    logic signed [31:0] ra;
    logic signed [31:0] id;
    logic signed [31:0] iq;
    logic signed [31:0] efd;
    logic signed [31:0] flux;
  } sample_t;

  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  // arctangent table of the rotation stages, q2.30
  localparam longint ATAN_TAB [0:29] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2};

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] bus_voltage = 0, bus_angle = 0, rotor_angle = 0;
  logic signed [31:0] direct_current = 0, quadrature_current = 0;
  logic signed [31:0] excitation_voltage = 0, field_flux_state = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] direct_voltage, quadrature_voltage;
  logic signed [31:0] active_power, air_gap_torque, field_current;

  // shadow copy of the configuration registers
  logic [30:0] rs_shadow = 31'd0;
  logic [30:0] xd_shadow = 31'd65536;
  logic [30:0] xdp_shadow = 31'd19661;
  kind_t kind_shadow = KIND_CLASSICAL;

  res_t expected_results [$];
  int mismatches = 0;
  int samples_sent = 0;
  int results_seen = 0;
  bit idle_on = 1;       // random gaps on both sides
  int hold_left = 0;     // long receiver hold-off, counted down by the monitor

  always #5 clk = ~clk;

  machine_terminal_signal_compute u_top (.*);

  function automatic logic signed [31:0] clamp_q16(input logic signed [127:0] w);
    if (w > 128'sd2147483647) return MAXV;
    if (w < -128'sd2147483648) return MINV;
    return w[31:0];
  endfunction

  // expected result of one sample under the current shadow settings
  function automatic res_t predict_terminal(input sample_t s);
    res_t r;
    longint d, ang, x, y, z, xs, ys, sn, cs, diff;
    logic signed [127:0] w, a, b, m;
    bit neg;
    neg = 0;
    d = longint'(s.ra) - longint'(s.ba);
    ang = d % TWO_PI_Q;
    if (ang < 0) ang += TWO_PI_Q;
    if (ang > PI_Q) ang -= TWO_PI_Q;
    // fold into the right half plane, flipping both outputs
    if (ang > HALF_PI_Q) begin
      ang -= PI_Q;
      neg = 1;
    end else if (ang < -HALF_PI_Q) begin
      ang += PI_Q;
      neg = 1;
    end
    z = ang * 16384;
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < ROT_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end else begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end
    end
    sn = neg ? -y : y;
    cs = neg ? -x : x;
    w = s.v; w = -(w * sn) + (128'sd1 <<< 29);
    r.vd = clamp_q16(w >>> 30);
    w = s.v; w = w * cs + (128'sd1 <<< 29);
    r.vq = clamp_q16(w >>> 30);
    a = r.vd; b = r.vq;
    w = (a * s.id + b * s.iq + 128'sd32768) >>> 16;
    r.power = clamp_q16(w);
    a = s.id; b = s.iq;
    m = a * a + b * b;
    a = $signed({97'd0, rs_shadow});
    b = (a * m + (128'sd1 <<< 31)) >>> 32;
    r.torque = clamp_q16(w + b);
    case (kind_shadow)
      KIND_CLASSICAL: r.fc = s.efd;
      KIND_FIFTH:     r.fc = s.flux;
      default: begin
        diff = longint'(xd_shadow) - longint'(xdp_shadow);
        a = diff; b = s.flux;
        r.fc = clamp_q16(b - ((a * s.id + 128'sd32768) >>> 16));
      end
    endcase
    return r;
  endfunction

  // register write, only while the pipeline is empty
  task automatic write_reg(input reg_idx_t idx, input logic [30:0] val);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    case (idx)
      REG_RS:   rs_shadow = val;
      REG_XD:   xd_shadow = val;
      REG_XDP:  xdp_shadow = val;
      REG_KIND: kind_shadow = kind_t'(val[1:0]);
    endcase
  endtask

  task automatic set_machine(input logic [30:0] rs, input logic [30:0] xd,
                             input logic [30:0] xdp, input logic [30:0] kind);
    write_reg(REG_RS, rs);
    write_reg(REG_XD, xd);
    write_reg(REG_XDP, xdp);
    write_reg(REG_KIND, kind);
  endtask

  // drain all outstanding results, then let the pipeline settle
  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // offer one sample and hold it until the transfer happens
  task automatic send_sample(input sample_t s);
    if (idle_on && $urandom_range(99) < 17) begin
      in_valid <= 0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_valid <= 1;
    bus_voltage <= s.v;
    bus_angle <= s.ba;
    rotor_angle <= s.ra;
    direct_current <= s.id;
    quadrature_current <= s.iq;
    excitation_voltage <= s.efd;
    field_flux_state <= s.flux;
    do @(posedge clk); while (!in_ready);
    expected_results.insert(expected_results.size(), predict_terminal(s));
    samples_sent++;
  endtask

  task automatic end_burst();
    in_valid <= 0;
    @(posedge clk);
  endtask

  function automatic sample_t any_sample();
    sample_t s;
    s.v = $urandom; s.ba = $urandom; s.ra = $urandom;
    s.id = $urandom; s.iq = $urandom; s.efd = $urandom; s.flux = $urandom;
    return s;
  endfunction

  // per-unit sized values, where the machine normally lives
  function automatic sample_t unit_sample();
    sample_t s;
    s = any_sample();
    s.v = $urandom_range(131072);
    s.ba = int'($urandom_range(2000000)) - 1000000;
    s.ra = int'($urandom_range(2000000)) - 1000000;
    s.id = int'($urandom_range(400000)) - 200000;
    s.iq = int'($urandom_range(400000)) - 200000;
    return s;
  endfunction

  function automatic sample_t mixed_sample();
    return ($urandom_range(2) == 0) ? any_sample() : unit_sample();
  endfunction

  // monitor: random ready, optional hold-off, in-order field compare
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (direct_voltage !== e.vd) begin
            $error("direct_voltage exp %0d got %0d", e.vd, direct_voltage);
            mismatches++;
          end
          if (quadrature_voltage !== e.vq) begin
            $error("quadrature_voltage exp %0d got %0d", e.vq, quadrature_voltage);
            mismatches++;
          end
          if (active_power !== e.power) begin
            $error("active_power exp %0d got %0d", e.power, active_power);
            mismatches++;
          end
          if (air_gap_torque !== e.torque) begin
            $error("air_gap_torque exp %0d got %0d", e.torque, air_gap_torque);
            mismatches++;
          end
          if (field_current !== e.fc) begin
            $error("field_current exp %0d got %0d", e.fc, field_current);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= idle_on ? ($urandom_range(99) >= 17) : 1'b1;
      end
    end
  end

  // edges of the fields, angle fold boundaries, saturation corners
  task automatic test_directed();
    sample_t s;
    int angs [12] = '{0, 102944, 102945, -102944, -102945, 205887, 205888,
                      -205887, 411775, -411775, MAXV, MINV};
    set_machine(31'h7fffffff, 31'h7fffffff, 31'd0, 31'(KIND_THIRD));
    foreach (angs[i]) begin
      s = unit_sample();
      s.ba = 0; s.ra = angs[i];
      s.v = (i % 3 == 0) ? MAXV : (i % 3 == 1) ? MINV : 32'sd65536;
      s.id = (i % 2) ? MINV : MAXV;
      s.iq = (i % 4 < 2) ? MAXV : MINV;
      s.flux = (i % 2) ? MAXV : MINV;
      send_sample(s);
    end
    s = any_sample();
    s.ra = MINV; s.ba = MAXV; s.v = 0; s.id = 0; s.iq = 0;
    send_sample(s);
    s.ra = MAXV; s.ba = MINV; s.v = MAXV; s.id = MINV; s.iq = MINV;
    send_sample(s);
    end_burst();
    wait_drained();
    // kind register takes only its low bits
    set_machine(31'd0, 31'd0, 31'h7fffffff, 31'h7ffffffe);
    for (int i = 0; i < 6; i++) begin
      s = any_sample();
      if (i < 3) s.id = i[0] ? MAXV : MINV;
      send_sample(s);
    end
    end_burst();
    wait_drained();
  endtask

  // every model kind with ordinary, extreme and random settings
  task automatic test_kinds();
    logic [30:0] vals [4] = '{31'd0, 31'h7fffffff, 31'd65536, 31'd19661};
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        if (c == 2)
          set_machine(31'($urandom), 31'($urandom), 31'($urandom), 31'(k));
        else
          set_machine(vals[$urandom_range(3)], vals[$urandom_range(3)],
                      vals[$urandom_range(3)], 31'(k));
        repeat (50) send_sample(mixed_sample());
        end_burst();
        wait_drained();
      end
    end
  endtask

  // long receiver stall so the pipeline fills and input stalls
  task automatic test_backpressure();
    set_machine(31'd3277, 31'd117965, 31'd19661, 31'(KIND_FOURTH));
    hold_left = 300;
    repeat (120) send_sample(unit_sample());
    end_burst();
    wait_drained();
  endtask

  // bulk random, one stretch with no gaps on either side
  task automatic test_random();
    set_machine(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom_range(3)));
    idle_on = 0;
    repeat (200) send_sample(mixed_sample());
    end_burst();
    wait_drained();
    idle_on = 1;
    for (int p = 0; p < 4; p++) begin
      set_machine(31'($urandom_range(6553)), 31'($urandom_range(200000)),
                  31'($urandom_range(65536)), 31'(p));
      repeat (150) send_sample(mixed_sample());
      end_burst();
      wait_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_kinds();
    test_backpressure();
    test_random();
    wait_drained();
    $display("covered %0d samples and %0d results over all model kinds,",
             samples_sent, results_seen);
    $display("angle folds, saturation corners and a long output stall");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
